[design/lmfs_pkg.sv]
// ----------------------------------------------------------------------------
// lmfs_pkg
// Shared types, codes and helpers for the 8x8 LED matrix framebuffer scanner.
// ----------------------------------------------------------------------------
package lmfs_pkg;

   localparam int unsigned ROW_W      = 3;
   localparam int unsigned PIX_W      = 8;
   localparam logic [ROW_W-1:0] LAST_ROW = 3'd7;

   // request codes
   typedef enum logic [1:0] {
      OP_POINT  = 2'd0,
      OP_CLEAR  = 2'd1,
      OP_FILL   = 2'd2,
      OP_RENDER = 2'd3
   } op_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_MODIFY,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic [1:0]       req_type;
      logic [ROW_W-1:0] col_start;
      logic [ROW_W-1:0] row_start;
      logic [ROW_W-1:0] col_end;
      logic [ROW_W-1:0] row_end;
      logic             pixel_on;
   } req_item_type;

   typedef struct packed {
      logic [PIX_W-1:0] first_byte;
      logic [PIX_W-1:0] second_byte;
      logic             last_row;
   } rsp_item_type;

   // frame memory command from the sequencer
   typedef struct packed {
      logic             rd_en;
      logic             wr_en;
      logic [ROW_W-1:0] addr;
      logic [PIX_W-1:0] wr_data;
   } mem_cmd_type;

   // column x maps to bit 7-x
   function automatic logic [PIX_W-1:0] column_mask(
      input logic [ROW_W-1:0] c_lo,
      input logic [ROW_W-1:0] c_hi
   );
      logic [PIX_W-1:0] m;
      m = '0;
      for (int x = 0; x < PIX_W; x++) begin
         if ((ROW_W'(x) >= c_lo) && (ROW_W'(x) <= c_hi)) begin
            m[PIX_W-1-x] = 1'b1;
         end
      end
      return m;
   endfunction

   function automatic logic [PIX_W-1:0] bit_reverse(input logic [PIX_W-1:0] v);
      logic [PIX_W-1:0] r;
      for (int b = 0; b < PIX_W; b++) begin
         r[PIX_W-1-b] = v[b];
      end
      return r;
   endfunction

   // active-low one-hot select for a scan step
   function automatic logic [PIX_W-1:0] row_select(input logic [ROW_W-1:0] step);
      logic [PIX_W-1:0] s;
      s = '1;
      s[step] = 1'b0;
      return s;
   endfunction

endpackage

[design/led_matrix_framebuffer_scan_top.sv]
// ----------------------------------------------------------------------------
// led_matrix_framebuffer_scan_top
// 8x8 one-bit LED matrix framebuffer with point and rectangle drawing and a
// row-scan render that emits one result per row.
// ----------------------------------------------------------------------------
// point request: the row is read from memory, then written back
// rectangle request: each row in turn is read from memory, then written back
// render: each row is read through the single memory port and then placed in the
// output register as a result; a stalled result holds the scan until it is taken
// reset: synchronous, clears the frame (row valid bits) and orientation at once
// ----------------------------------------------------------------------------
module led_matrix_framebuffer_scan_top
   import lmfs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_data,
   input  logic         csr_wr_en,
   input  logic         csr_wr_data
);

   mem_cmd_type      mem_cmd;
   logic [PIX_W-1:0] mem_rd_data;

   // sequencer
   lmfs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .mem_cmd     (mem_cmd),
      .mem_rd_data (mem_rd_data)
   );

   // frame storage
   lmfs_frame_mem u_frame_mem (
      .clock   (clock),
      .reset   (reset),
      .cmd     (mem_cmd),
      .rd_data (mem_rd_data)
   );

endmodule

[design/lmfs_frame_mem.sv]
// ----------------------------------------------------------------------------
// lmfs_frame_mem
// Eight-row frame memory, one byte per row, registered read port. Per-row
// valid bits make unwritten rows read as zero right after reset.
// ----------------------------------------------------------------------------
module lmfs_frame_mem
   import lmfs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  mem_cmd_type      cmd,
   output logic [PIX_W-1:0] rd_data
);

   logic [PIX_W-1:0]       mem_ff [PIX_W];
   logic [PIX_W-1:0]       valid_ff;
   logic [PIX_W-1:0]       rd_raw_ff;
   logic                   rd_valid_ff;

   // row storage, no reset
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_ff[cmd.addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_raw_ff <= mem_ff[cmd.addr];
      end
   end

   // row valid bits, cleared at once by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (cmd.wr_en) begin
            valid_ff[cmd.addr] <= 1'b1;
         end
         if (cmd.rd_en) begin
            rd_valid_ff <= valid_ff[cmd.addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_raw_ff : '0;

endmodule

[design/lmfs_ctrl.sv]
// ----------------------------------------------------------------------------
// lmfs_ctrl
// Request sequencer: read-modify-write of rows for drawing requests and a
// row-by-row scan into the output register for render requests.
// ----------------------------------------------------------------------------
module lmfs_ctrl
   import lmfs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_item_type     req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_item_type     rsp_data,
   input  logic             csr_wr_en,
   input  logic             csr_wr_data,
   output mem_cmd_type      mem_cmd,
   input  logic [PIX_W-1:0] mem_rd_data
);

   state_type        state_ff, state_in;
   op_type           op_ff, op_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [ROW_W-1:0] row_end_ff, row_end_in;
   logic [PIX_W-1:0] mask_ff, mask_in;
   logic             set_ff, set_in;
   logic             orient_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_item_type     rsp_data_ff, rsp_data_in;

   logic             accept;
   logic             rsp_free;
   logic             range_empty;
   op_type           req_op;

   assign accept      = req_valid && req_ready;
   assign rsp_free    = !rsp_valid_ff || rsp_ready;
   assign req_op      = op_type'(req_data.req_type);
   assign range_empty = (req_data.row_end < req_data.row_start) ||
                        (req_data.col_end < req_data.col_start);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if ((req_op == OP_CLEAR || req_op == OP_FILL) && range_empty) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = (op_ff == OP_RENDER) ? ST_SCAN : ST_MODIFY;
         end
         ST_MODIFY: begin
            if (op_ff == OP_POINT || row_ff == row_end_ff) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_SCAN: begin
            if (rsp_free) begin
               state_in = (row_ff == LAST_ROW) ? ST_IDLE : ST_READ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs: handshake and memory command
   always_comb begin
      req_ready       = (state_ff == ST_IDLE);
      mem_cmd.rd_en   = (state_ff == ST_READ);
      mem_cmd.wr_en   = (state_ff == ST_MODIFY);
      mem_cmd.wr_data = set_ff ? (mem_rd_data | mask_ff) : (mem_rd_data & ~mask_ff);
      if (op_ff == OP_RENDER && orient_ff) begin
         mem_cmd.addr = ~row_ff;
      end else begin
         mem_cmd.addr = row_ff;
      end
   end

   // request latch, row walk and output register next values
   always_comb begin
      op_in        = op_ff;
      row_in       = row_ff;
      row_end_in   = row_end_ff;
      mask_in      = mask_ff;
      set_in       = set_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;

      if (accept) begin
         op_in      = req_op;
         row_end_in = req_data.row_end;
         row_in     = (req_op == OP_RENDER) ? '0 : req_data.row_start;
         if (req_op == OP_POINT) begin
            mask_in = column_mask(req_data.col_start, req_data.col_start);
            set_in  = req_data.pixel_on;
         end else begin
            mask_in = column_mask(req_data.col_start, req_data.col_end);
            set_in  = (req_op == OP_FILL);
         end
      end

      if (state_ff == ST_MODIFY) begin
         row_in = row_ff + 1'b1;
      end

      if (state_ff == ST_SCAN && rsp_free) begin
         row_in                  = row_ff + 1'b1;
         rsp_valid_in            = 1'b1;
         rsp_data_in.first_byte  = orient_ff ? mem_rd_data : bit_reverse(mem_rd_data);
         rsp_data_in.second_byte = row_select(row_ff);
         rsp_data_in.last_row    = (row_ff == LAST_ROW);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         orient_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            orient_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      row_ff      <= row_in;
      row_end_ff  <= row_end_in;
      mask_ff     <= mask_in;
      set_ff      <= set_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[design/lmfs_checker.sv]
// ----------------------------------------------------------------------------
// lmfs_checker
// Port-level checks for the framebuffer scanner, bound to the top level.
// ----------------------------------------------------------------------------
module lmfs_checker
   import lmfs_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_item_type rsp_data
);

   // no result right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // exactly one row selected
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $countones(rsp_data.second_byte) == 7)
      else $error("row select not one-hot low");

   // last row flag matches the final scan step select
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last_row == (rsp_data.second_byte == 8'h7F)))
      else $error("last row flag mismatch");

   // no new request is taken while a scan result other than the last one is valid
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_row |-> !req_ready)
      else $error("request accepted during render scan");

endmodule

bind led_matrix_framebuffer_scan_top lmfs_checker u_lmfs_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_data    (rsp_data)
);
